/* design/pdca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdca_pkg
// Shared constants, types and codes of the pedometer accumulator.
// ----------------------------------------------------------------------------
package pdca_pkg;

  localparam int SAMPLE_RATE   = 50;
  localparam int INTERVAL_GATE = 65500;
  localparam int SPEED_MAX     = 16383;

  // step length bands, interval thresholds
  localparam int TH_FULL = SAMPLE_RATE;
  localparam int TH_23   = SAMPLE_RATE * 2 / 3;
  localparam int TH_12   = SAMPLE_RATE / 2;
  localparam int TH_25   = SAMPLE_RATE * 2 / 5;
  localparam int TH_13   = SAMPLE_RATE / 3;
  localparam int TH_14   = SAMPLE_RATE / 4;

  // output scaling divisors
  localparam int DIST_DIV = 100;
  localparam int CAL_DIV  = 100000;
  localparam int MIN_DIV  = SAMPLE_RATE * 60;

  // widths
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CNT_W      = 16;
  localparam int ACC_W      = 32;
  localparam int SPEED_W    = 14;
  localparam int IVL_W      = $clog2(SAMPLE_RATE + 1);
  localparam int LEN_W      = 9;                       // 6h/5 <= 306
  localparam int NUM_W      = 11;                      // 6h <= 1530
  localparam int ACT_W      = IVL_W + CNT_W;
  localparam int DPROD_W    = LEN_W + CNT_W;
  localparam int CPROD_W    = CNT_W + CFG_W;
  localparam int SPD_NUM_W  = $clog2(306 * SAMPLE_RATE + 1);

  // divider: 32-bit dividend, 2 quotient bits per cycle
  localparam int DVD_W      = 32;
  localparam int DVS_W      = 17;
  localparam int PAIR_CNT_W = 4;
  localparam int IVL_PAIRS  = CNT_W / 2;
  localparam int LEN_PAIRS  = (NUM_W + 1) / 2;
  localparam int SPD_PAIRS  = (SPD_NUM_W + 1) / 2;
  localparam int OUT_PAIRS  = DVD_W / 2;
  localparam int SPD_SHIFT  = DVD_W - 2 * SPD_PAIRS;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK   = 2'd2;

  localparam logic [CFG_W-1:0] HEIGHT_RST = 8'd170;
  localparam logic [CFG_W-1:0] WEIGHT_RST = 8'd70;
  localparam logic [CFG_W-1:0] TICK_RST   = 8'd26;

  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_IVL_GO,
    ST_IVL_WAIT,
    ST_LEN_GO,
    ST_LEN_WAIT,
    ST_SPD_GO,
    ST_SPD_WAIT,
    ST_CAL,
    ST_ACC,
    ST_OUT_GO,
    ST_OUT_WAIT,
    ST_RESULT
  } pdca_state_e;

  typedef struct packed {
    logic latch_in;
    logic tick;
    logic ivl_start;
    logic ivl_latch;
    logic len_start;
    logic len_latch;
    logic dist_mul;
    logic spd_start;
    logic spd_latch;
    logic cal_mul;
    logic accum;
    logic odiv_start;
    logic odiv_latch;
    logic load_out;
  } pdca_cmd_t;

  typedef struct packed {
    logic action;
    logic cnt_gt;
    logic ivl_zero;
    logic div_done;
    logic odiv_done;
  } pdca_sts_t;

endpackage

/* design/pdca_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdca_div
// Iterative restoring divider, two quotient bits per cycle. The caller
// left-aligns the dividend so that 2*(pairs_i+1) steps cover its bits.
// ----------------------------------------------------------------------------
module pdca_div
  import pdca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [PAIR_CNT_W-1:0] pairs_i,
  input  logic [DVD_W-1:0]      dividend_i,
  input  logic [DVS_W-1:0]      divisor_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quotient_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [PAIR_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]      quo_q, quo_d;
  logic [DVS_W-1:0]      rem_q, rem_d;
  logic [DVS_W-1:0]      dvs_q, dvs_d;

  logic [DVS_W:0]   t1, t2;
  logic [DVS_W-1:0] r1, r2;
  logic             b1, b2;

  always_comb begin
    t1 = {rem_q, quo_q[DVD_W-1]};
    b1 = (t1 >= {1'b0, dvs_q});
    r1 = b1 ? DVS_W'(t1 - {1'b0, dvs_q}) : t1[DVS_W-1:0];
    t2 = {r1, quo_q[DVD_W-2]};
    b2 = (t2 >= {1'b0, dvs_q});
    r2 = b2 ? DVS_W'(t2 - {1'b0, dvs_q}) : t2[DVS_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = pairs_i;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-3:0], b1, b2};
      rem_d = r2;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* design/pdca_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdca_ctrl
// Sequencer: walks one item through tick update, interval divide, step
// length, speed, accumulation and output scaling; owns the output valid.
// ----------------------------------------------------------------------------
module pdca_ctrl
  import pdca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  pdca_sts_t sts_i,
  output pdca_cmd_t cmd_o
);

  pdca_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_TICK;
      ST_TICK: begin
        if (sts_i.action == ACT_CLEAR) state_d = ST_RESULT;
        else if (sts_i.cnt_gt)         state_d = ST_IVL_GO;
        else                           state_d = ST_RESULT;
      end
      ST_IVL_GO:   state_d = ST_IVL_WAIT;
      ST_IVL_WAIT: if (sts_i.div_done) state_d = ST_LEN_GO;
      ST_LEN_GO:   state_d = ST_LEN_WAIT;
      ST_LEN_WAIT: if (sts_i.div_done) state_d = ST_SPD_GO;
      ST_SPD_GO:   state_d = sts_i.ivl_zero ? ST_CAL : ST_SPD_WAIT;
      ST_SPD_WAIT: if (sts_i.div_done) state_d = ST_CAL;
      ST_CAL:      state_d = ST_ACC;
      ST_ACC:      state_d = ST_OUT_GO;
      ST_OUT_GO:   state_d = ST_OUT_WAIT;
      ST_OUT_WAIT: if (sts_i.odiv_done) state_d = ST_RESULT;
      ST_RESULT:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    in_stall_o       = (state_q != ST_IDLE);
    cmd_o.latch_in   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.tick       = (state_q == ST_TICK);
    cmd_o.ivl_start  = (state_q == ST_IVL_GO);
    cmd_o.ivl_latch  = (state_q == ST_IVL_WAIT) && sts_i.div_done;
    cmd_o.len_start  = (state_q == ST_LEN_GO);
    cmd_o.len_latch  = (state_q == ST_LEN_WAIT) && sts_i.div_done;
    cmd_o.dist_mul   = (state_q == ST_SPD_GO);
    cmd_o.spd_start  = (state_q == ST_SPD_GO) && !sts_i.ivl_zero;
    cmd_o.spd_latch  = (state_q == ST_SPD_WAIT) && sts_i.div_done;
    cmd_o.cal_mul    = (state_q == ST_CAL);
    cmd_o.accum      = (state_q == ST_ACC);
    cmd_o.odiv_start = (state_q == ST_OUT_GO);
    cmd_o.odiv_latch = (state_q == ST_OUT_WAIT) && sts_i.odiv_done;
    cmd_o.load_out   = (state_q == ST_RESULT) && out_free;

    out_valid_d = out_valid_q;
    if (cmd_o.load_out)                out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/pdca_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdca_dp
// Datapath: configuration, accumulator state, one divider shared by the step
// path and distance scaling, two for kcal and minutes, output beat registers.
// ----------------------------------------------------------------------------
module pdca_dp
  import pdca_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 action_i,
  input  logic [CNT_W-1:0]     step_count_i,
  input  pdca_cmd_t            cmd_i,
  output pdca_sts_t            sts_o,
  output logic                 steps_credited_o,
  output logic [SPEED_W-1:0]   speed_cm_per_s_o,
  output logic [CNT_W-1:0]     total_steps_o,
  output logic [CNT_W-1:0]     distance_m_o,
  output logic [CNT_W-1:0]     calories_kcal_o,
  output logic [CNT_W-1:0]     active_minutes_o
);

  // configuration
  logic [CFG_W-1:0] height_q, weight_q, tick_inc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q   <= HEIGHT_RST;
      weight_q   <= WEIGHT_RST;
      tick_inc_q <= TICK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEIGHT: height_q   <= cfg_data_i;
        CFG_WEIGHT: weight_q   <= cfg_data_i;
        CFG_TICK:   tick_inc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // accumulator state
  logic [CNT_W-1:0] last_q, interval_q;
  logic [ACC_W-1:0] active_q, dist_cm_q, cal_q;
  logic [CNT_W-1:0] dist_m_q, kcal_q, minutes_q;
  logic             credited_q;
  logic [SPEED_W-1:0] speed_q;

  // per-item working registers
  logic               action_q;
  logic [CNT_W-1:0]   count_q, steps_q;
  logic [IVL_W-1:0]   ivl_q;
  logic [LEN_W-1:0]   len_q;
  logic [ACT_W-1:0]   act_prod_q;
  logic [CNT_W-1:0]   dist_q;
  logic [CPROD_W-1:0] cal_prod_q;

  // divider signals
  logic                  div_a_start;
  logic [PAIR_CNT_W-1:0] div_a_pairs;
  logic [DVD_W-1:0]      div_a_dvd;
  logic [DVS_W-1:0]      div_a_dvs;
  logic                  div_a_done, div_b_done, div_c_done;
  logic [DVD_W-1:0]      quo_a, quo_b, quo_c;

  logic [CNT_W:0]       tick_sum;
  logic [CNT_W-1:0]     tick_next;
  logic [2:0]           len_k, len_den;
  logic [NUM_W-1:0]     len_num;
  logic [SPD_NUM_W-1:0] spd_num;
  logic [DPROD_W-1:0]   dist_full;
  logic [CPROD_W+2:0]   cal5;

  always_comb begin
    tick_sum  = {1'b0, interval_q} + {{(CNT_W+1-CFG_W){1'b0}}, tick_inc_q};
    tick_next = tick_sum[CNT_W] ? {CNT_W{1'b1}} : tick_sum[CNT_W-1:0];
  end

  // step length band: numerator factor and divisor
  always_comb begin
    if (32'(ivl_q) >= TH_FULL) begin
      len_k = 3'd1; len_den = 3'd5;
    end else if (32'(ivl_q) > TH_23) begin
      len_k = 3'd1; len_den = 3'd4;
    end else if (32'(ivl_q) > TH_12) begin
      len_k = 3'd1; len_den = 3'd3;
    end else if (32'(ivl_q) > TH_25) begin
      len_k = 3'd1; len_den = 3'd2;
    end else if (32'(ivl_q) > TH_13) begin
      len_k = 3'd5; len_den = 3'd6;
    end else if (32'(ivl_q) > TH_14) begin
      len_k = 3'd1; len_den = 3'd1;
    end else begin
      len_k = 3'd6; len_den = 3'd5;
    end
    len_num = NUM_W'(height_q) * NUM_W'(len_k);
  end

  assign spd_num   = SPD_NUM_W'(len_q * SAMPLE_RATE);
  assign dist_full = DPROD_W'(len_q) * DPROD_W'(steps_q);
  assign cal5      = {3'b0, cal_prod_q} + {1'b0, cal_prod_q, 2'b0};

  // shared divider operand select
  always_comb begin
    div_a_start = cmd_i.ivl_start | cmd_i.len_start | cmd_i.spd_start | cmd_i.odiv_start;
    div_a_pairs = PAIR_CNT_W'(OUT_PAIRS - 1);
    div_a_dvd   = dist_cm_q;
    div_a_dvs   = DVS_W'(DIST_DIV);
    if (cmd_i.ivl_start) begin
      div_a_pairs = PAIR_CNT_W'(IVL_PAIRS - 1);
      div_a_dvd   = {interval_q, {(DVD_W-CNT_W){1'b0}}};
      div_a_dvs   = DVS_W'(steps_q);
    end else if (cmd_i.len_start) begin
      div_a_pairs = PAIR_CNT_W'(LEN_PAIRS - 1);
      div_a_dvd   = DVD_W'(len_num) << (DVD_W - 2 * LEN_PAIRS);
      div_a_dvs   = DVS_W'(len_den);
    end else if (cmd_i.spd_start) begin
      div_a_pairs = PAIR_CNT_W'(SPD_PAIRS - 1);
      div_a_dvd   = DVD_W'(spd_num) << SPD_SHIFT;
      div_a_dvs   = DVS_W'(ivl_q);
    end
  end

  pdca_div u_div_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_a_start),
    .pairs_i    (div_a_pairs),
    .dividend_i (div_a_dvd),
    .divisor_i  (div_a_dvs),
    .done_o     (div_a_done),
    .quotient_o (quo_a)
  );

  pdca_div u_div_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.odiv_start),
    .pairs_i    (PAIR_CNT_W'(OUT_PAIRS - 1)),
    .dividend_i (cal_q),
    .divisor_i  (DVS_W'(CAL_DIV)),
    .done_o     (div_b_done),
    .quotient_o (quo_b)
  );

  pdca_div u_div_c (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.odiv_start),
    .pairs_i    (PAIR_CNT_W'(OUT_PAIRS - 1)),
    .dividend_i (active_q),
    .divisor_i  (DVS_W'(MIN_DIV)),
    .done_o     (div_c_done),
    .quotient_o (quo_c)
  );

  // all three output divides run the same length
  always_comb begin
    sts_o.action    = action_q;
    sts_o.cnt_gt    = (count_q > last_q);
    sts_o.ivl_zero  = (ivl_q == '0);
    sts_o.div_done  = div_a_done;
    sts_o.odiv_done = div_a_done & div_b_done & div_c_done;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= '0;
      interval_q <= '0;
      active_q   <= '0;
      dist_cm_q  <= '0;
      cal_q      <= '0;
      dist_m_q   <= '0;
      kcal_q     <= '0;
      minutes_q  <= '0;
      credited_q <= 1'b0;
      speed_q    <= '0;
    end else begin
      if (cmd_i.tick) begin
        credited_q <= 1'b0;
        speed_q    <= '0;
        if (action_q == ACT_CLEAR) begin
          last_q     <= '0;
          interval_q <= '0;
          active_q   <= '0;
          dist_cm_q  <= '0;
          cal_q      <= '0;
          dist_m_q   <= '0;
          kcal_q     <= '0;
          minutes_q  <= '0;
        end else begin
          if (32'(interval_q) < INTERVAL_GATE) interval_q <= tick_next;
          if (count_q < last_q) last_q <= count_q;
        end
      end
      if (cmd_i.len_latch) active_q <= active_q + ACC_W'(act_prod_q);
      if (cmd_i.spd_latch) begin
        speed_q <= (quo_a > DVD_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX) : quo_a[SPEED_W-1:0];
      end
      if (cmd_i.accum) begin
        dist_cm_q  <= dist_cm_q + ACC_W'(dist_q);
        cal_q      <= cal_q + ACC_W'(cal5[CPROD_W+2:2]);
        last_q     <= count_q;
        interval_q <= '0;
        credited_q <= 1'b1;
      end
      if (cmd_i.odiv_latch) begin
        dist_m_q  <= quo_a[CNT_W-1:0];
        kcal_q    <= quo_b[CNT_W-1:0];
        minutes_q <= quo_c[CNT_W-1:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      action_q <= action_i;
      count_q  <= step_count_i;
    end
    if (cmd_i.tick) steps_q <= count_q - last_q;
    if (cmd_i.ivl_latch) begin
      ivl_q <= (quo_a > DVD_W'(SAMPLE_RATE)) ? IVL_W'(SAMPLE_RATE) : quo_a[IVL_W-1:0];
    end
    if (cmd_i.len_start) act_prod_q <= ACT_W'(ivl_q) * ACT_W'(steps_q);
    if (cmd_i.len_latch) len_q <= quo_a[LEN_W-1:0];
    if (cmd_i.dist_mul)  dist_q <= dist_full[CNT_W-1:0];
    if (cmd_i.cal_mul)   cal_prod_q <= CPROD_W'(dist_q) * CPROD_W'(weight_q);
  end

  // output beat registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      steps_credited_o <= credited_q;
      speed_cm_per_s_o <= speed_q;
      total_steps_o    <= last_q;
      distance_m_o     <= dist_m_q;
      calories_kcal_o  <= kcal_q;
      active_minutes_o <= minutes_q;
    end
  end

endmodule

/* design/pedometer_distance_calorie_accumulator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedometer_distance_calorie_accumulator_unit
// Step count to interval, speed, distance, calories and active minutes.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+---------------------
//  in      | action_i, step_count_i                    | in_valid_i/in_stall_o
//  out     | steps_credited_o .. active_minutes_o      | out_valid_o/out_stall_i
//  cfg     | cfg_idx_i, cfg_data_i                     | cfg_we_i
//
//  A beat that credits new steps runs the shared two-bit-per-cycle divider
//  for interval, step length and speed (each with launch and wait states),
//  then for distance beside the calorie and minute output divides. The
//  speed divide is skipped when the interval is zero. Clear, no-change and
//  count-fall beats skip all divides. One beat is in flight at a time; a
//  finished result waits in the output register while out_stall_i is high,
//  and the next input beat is taken meanwhile. Reset restores the config
//  defaults and clears accumulators, not the working or output registers.
// ----------------------------------------------------------------------------
module pedometer_distance_calorie_accumulator_unit
  import pdca_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 action_i,
  input  logic [CNT_W-1:0]     step_count_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 steps_credited_o,
  output logic [SPEED_W-1:0]   speed_cm_per_s_o,
  output logic [CNT_W-1:0]     total_steps_o,
  output logic [CNT_W-1:0]     distance_m_o,
  output logic [CNT_W-1:0]     calories_kcal_o,
  output logic [CNT_W-1:0]     active_minutes_o
);

  pdca_cmd_t cmd;
  pdca_sts_t sts;

  pdca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pdca_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .action_i         (action_i),
    .step_count_i     (step_count_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .steps_credited_o (steps_credited_o),
    .speed_cm_per_s_o (speed_cm_per_s_o),
    .total_steps_o    (total_steps_o),
    .distance_m_o     (distance_m_o),
    .calories_kcal_o  (calories_kcal_o),
    .active_minutes_o (active_minutes_o)
  );

endmodule
